// ----- hdl/gri_pkg.sv -----
// Shared types and constants of the gyro rate integrator.
// Used by gri_ctrl, gri_datapath and gyro_rate_integrator_unit; no dependencies.
package gri_pkg;

   localparam logic [2:0] CMD_SAMPLE     = 3'd0;
   localparam logic [2:0] CMD_RESET_AXIS = 3'd1;
   localparam logic [2:0] CMD_RESET_ALL  = 3'd2;
   localparam logic [2:0] CMD_CALIBRATE  = 3'd3;
   localparam logic [2:0] CMD_SET_SCALE  = 3'd4;

   localparam logic [1:0] CSR_ANGLE_MODE   = 2'd0;
   localparam logic [1:0] CSR_FULL_TURN    = 2'd1;
   localparam logic [1:0] CSR_TICK_SECONDS = 2'd2;

   localparam logic [1:0] MODE_DEGREES = 2'd0;
   localparam logic [1:0] MODE_RADIANS = 2'd1;
   localparam logic [1:0] MODE_RAW     = 2'd2;

   localparam logic [1:0] AXIS_NONE = 2'd3;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   localparam logic [31:0] RAD_PER_DEG_Q32 = 32'd74961321;
   localparam int          DIV_STEPS       = 80;
   localparam logic [6:0]  DIV_LAST        = 7'(DIV_STEPS - 1);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_UPDATE,
      OP_SMUL,
      OP_SACC,
      OP_MLO,
      OP_MHI,
      OP_DINIT,
      OP_DIV,
      OP_RLO,
      OP_RHI,
      OP_AFIN,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic       is_sample;
      logic [1:0] idx;
      logic [1:0] mode;
      logic       scale_zero;
      logic       div_last;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SMUL,
      ST_SACC,
      ST_ASTART,
      ST_MLO,
      ST_MHI,
      ST_DINIT,
      ST_DIV,
      ST_RLO,
      ST_RHI,
      ST_AFIN,
      ST_OUT
   } ctl_state_type;

endpackage

// ----- hdl/gri_datapath.sv -----
// Datapath of the gyro rate integrator: axis state, configuration registers,
// shared multiplier, restoring divider and result registers. Uses gri_pkg.
module gri_datapath #(
   parameter int          START_SETTLE  = 200,
   parameter int          RESET_SETTLE  = 100,
   parameter logic [47:0] DEFAULT_SCALE = 48'd4000000
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gri_pkg::dp_cmd_type    cmd,
   output gri_pkg::dp_status_type status,
   input  logic [2:0]             req_cmd,
   input  logic [1:0]             req_axis,
   input  logic [15:0]            req_rate_x,
   input  logic [15:0]            req_rate_y,
   input  logic [15:0]            req_rate_z,
   input  logic [31:0]            req_interval_ticks,
   input  logic [47:0]            req_scale_in,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data,
   output logic [31:0]            rsp_angle_x,
   output logic [31:0]            rsp_angle_y,
   output logic [31:0]            rsp_angle_z,
   output logic                   rsp_calibrating,
   output logic [47:0]            rsp_scale_out
);

   logic [1:0]  mode_ff;
   logic [15:0] fta_ff;
   logic [31:0] tick_ff;

   logic [2:0]  cmd_ff;
   logic [1:0]  axis_ff;
   logic [15:0] rate_ff [0:2];
   logic [31:0] ticks_raw_ff;
   logic [47:0] scale_in_ff;

   logic [15:0] centre_ff [0:2];
   logic [15:0] last_ff [0:2];
   logic [47:0] acc_ff [0:2];
   logic [47:0] scale_ff [0:2];
   logic [7:0]  settle_ff;
   logic [31:0] prev_ff;
   logic        cal_ff;
   logic [1:0]  idx_ff;

   logic signed [49:0] smul_ff;
   logic [95:0] prod_ff;
   logic [79:0] num_ff;
   logic [47:0] rem_ff;
   logic [79:0] quo_ff;
   logic [6:0]  dcnt_ff;
   logic [31:0] ang_ff [0:2];
   logic [47:0] scale_out_ff;

   logic        ok;
   logic [47:0] sel_acc;
   logic [47:0] sel_scale;
   logic [15:0] sel_last;
   logic [15:0] sel_centre;
   logic        acc_neg;
   logic        scl_neg;
   logic [47:0] ma;
   logic [47:0] ms;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [48:0] dtrial;
   logic        dge;
   logic [48:0] dnext;
   logic signed [16:0] dval;
   logic signed [49:0] smul_c;
   logic signed [50:0] ssum;
   logic [47:0] acc_sat;
   logic [31:0] tk;
   logic        f_zero;
   logic        f_neg;
   logic        f_huge;
   logic [31:0] f_mag;
   logic [31:0] f_angle;

   assign ok         = idx_ff != gri_pkg::AXIS_NONE;
   assign sel_acc    = ok ? acc_ff[idx_ff] : '0;
   assign sel_scale  = ok ? scale_ff[idx_ff] : '0;
   assign sel_last   = ok ? last_ff[idx_ff] : '0;
   assign sel_centre = ok ? centre_ff[idx_ff] : '0;
   assign acc_neg    = sel_acc[47];
   assign scl_neg    = sel_scale[47];
   assign ma         = acc_neg ? (48'd0 - sel_acc) : sel_acc;
   assign ms         = scl_neg ? (48'd0 - sel_scale) : sel_scale;
   assign tk         = ticks_raw_ff[31] ? prev_ff : ticks_raw_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         gri_pkg::OP_MLO: begin
            mul_a = ma[31:0];
            mul_b = (mode_ff == gri_pkg::MODE_RAW) ? tick_ff : {16'd0, fta_ff};
         end
         gri_pkg::OP_MHI: begin
            mul_a = {16'd0, ma[47:32]};
            mul_b = (mode_ff == gri_pkg::MODE_RAW) ? tick_ff : {16'd0, fta_ff};
         end
         gri_pkg::OP_RLO: begin
            mul_a = quo_ff[31:0];
            mul_b = gri_pkg::RAD_PER_DEG_Q32;
         end
         gri_pkg::OP_RHI: begin
            mul_a = {8'd0, quo_ff[55:32]};
            mul_b = gri_pkg::RAD_PER_DEG_Q32;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = 64'(mul_a) * 64'(mul_b);
   assign dtrial = {rem_ff, num_ff[79]};
   assign dge    = dtrial >= {1'b0, ms};
   assign dnext  = dge ? (dtrial - {1'b0, ms}) : dtrial;

   assign dval   = $signed({sel_last[15], sel_last}) - $signed({sel_centre[15], sel_centre});
   assign smul_c = 50'(dval) * $signed({18'd0, prev_ff});
   assign ssum   = 51'($signed(sel_acc)) + 51'(smul_ff);

   always_comb begin
      if (ssum[50:47] == 4'b0000 || ssum[50:47] == 4'b1111) begin
         acc_sat = ssum[47:0];
      end else if (ssum[50]) begin
         acc_sat = {1'b1, 47'd0};
      end else begin
         acc_sat = {1'b0, {47{1'b1}}};
      end
   end

   always_comb begin
      f_zero = 1'b0;
      f_neg  = acc_neg;
      f_huge = 1'b0;
      f_mag  = '0;
      case (mode_ff)
         gri_pkg::MODE_RAW: begin
            f_huge = |prod_ff[95:47];
            f_mag  = prod_ff[47:16];
         end
         gri_pkg::MODE_DEGREES, gri_pkg::MODE_RADIANS: begin
            if (sel_scale == '0) begin
               f_zero = sel_acc == '0;
               f_huge = 1'b1;
            end else begin
               f_neg = acc_neg ^ scl_neg;
               if (|quo_ff[79:56]) begin
                  f_huge = 1'b1;
               end else if (mode_ff == gri_pkg::MODE_DEGREES) begin
                  f_huge = |quo_ff[55:32];
                  f_mag  = quo_ff[31:0];
               end else begin
                  f_huge = |prod_ff[95:64];
                  f_mag  = prod_ff[63:32];
               end
            end
         end
         default: begin
            f_zero = 1'b1;
         end
      endcase
      if (f_zero) begin
         f_angle = '0;
      end else if (f_neg) begin
         f_angle = (f_huge || f_mag[31]) ? 32'h8000_0000 : (32'd0 - f_mag);
      end else begin
         f_angle = (f_huge || f_mag[31]) ? 32'h7FFF_FFFF : f_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= gri_pkg::MODE_DEGREES;
         fta_ff    <= 16'd360;
         tick_ff   <= 32'd4295;
         settle_ff <= 8'(START_SETTLE);
         prev_ff   <= '0;
         cal_ff    <= 1'b0;
         idx_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            centre_ff[i] <= '0;
            last_ff[i]   <= '0;
            acc_ff[i]    <= '0;
            scale_ff[i]  <= DEFAULT_SCALE;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               gri_pkg::CSR_ANGLE_MODE:   mode_ff <= csr_data[1:0];
               gri_pkg::CSR_FULL_TURN:    fta_ff  <= csr_data[15:0];
               gri_pkg::CSR_TICK_SECONDS: tick_ff <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            gri_pkg::OP_LOAD: begin
               idx_ff <= req_axis;
            end
            gri_pkg::OP_UPDATE: begin
               idx_ff <= '0;
               if (cmd_ff == gri_pkg::CMD_SAMPLE) begin
                  prev_ff <= tk;
                  for (int i = 0; i < 3; i++) begin
                     last_ff[i] <= rate_ff[i];
                     if (settle_ff != '0) begin
                        centre_ff[i] <= rate_ff[i];
                        acc_ff[i]    <= '0;
                     end
                  end
                  if (settle_ff != '0) begin
                     settle_ff <= settle_ff - 8'd1;
                  end
               end else if (cmd_ff == gri_pkg::CMD_RESET_ALL) begin
                  settle_ff <= 8'(RESET_SETTLE);
               end else if (ok) begin
                  case (cmd_ff)
                     gri_pkg::CMD_RESET_AXIS: begin
                        centre_ff[idx_ff] <= last_ff[idx_ff];
                        acc_ff[idx_ff]    <= '0;
                     end
                     gri_pkg::CMD_CALIBRATE: begin
                        centre_ff[idx_ff] <= last_ff[idx_ff];
                        acc_ff[idx_ff]    <= '0;
                        cal_ff            <= !cal_ff;
                        if (cal_ff) begin
                           scale_ff[idx_ff] <= acc_ff[idx_ff];
                        end
                     end
                     gri_pkg::CMD_SET_SCALE: begin
                        scale_ff[idx_ff] <= scale_in_ff;
                     end
                     default: ;
                  endcase
               end
            end
            gri_pkg::OP_SACC: begin
               if (ok) begin
                  acc_ff[idx_ff] <= acc_sat;
               end
               idx_ff <= (idx_ff == gri_pkg::AXIS_LAST) ? 2'd0 : idx_ff + 2'd1;
            end
            gri_pkg::OP_AFIN: begin
               idx_ff <= (idx_ff == gri_pkg::AXIS_LAST) ? 2'd0 : idx_ff + 2'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         gri_pkg::OP_LOAD: begin
            cmd_ff       <= req_cmd;
            axis_ff      <= req_axis;
            rate_ff[0]   <= req_rate_x;
            rate_ff[1]   <= req_rate_y;
            rate_ff[2]   <= req_rate_z;
            ticks_raw_ff <= req_interval_ticks;
            scale_in_ff  <= req_scale_in;
            scale_out_ff <= '0;
         end
         gri_pkg::OP_SMUL: begin
            smul_ff <= smul_c;
         end
         gri_pkg::OP_MLO, gri_pkg::OP_RLO: begin
            prod_ff <= 96'(mul_p);
         end
         gri_pkg::OP_MHI, gri_pkg::OP_RHI: begin
            prod_ff <= prod_ff + {mul_p, 32'd0};
         end
         gri_pkg::OP_DINIT: begin
            num_ff  <= {prod_ff[63:0], 16'd0};
            rem_ff  <= '0;
            quo_ff  <= '0;
            dcnt_ff <= '0;
         end
         gri_pkg::OP_DIV: begin
            rem_ff  <= dnext[47:0];
            num_ff  <= {num_ff[78:0], 1'b0};
            quo_ff  <= {quo_ff[78:0], dge};
            dcnt_ff <= dcnt_ff + 7'd1;
         end
         gri_pkg::OP_AFIN: begin
            if (ok) begin
               ang_ff[idx_ff] <= f_angle;
            end
            if (idx_ff == axis_ff) begin
               scale_out_ff <= sel_scale;
            end
         end
         gri_pkg::OP_OUT: begin
            rsp_angle_x     <= ang_ff[0];
            rsp_angle_y     <= ang_ff[1];
            rsp_angle_z     <= ang_ff[2];
            rsp_calibrating <= cal_ff;
            rsp_scale_out   <= scale_out_ff;
         end
         default: ;
      endcase
   end

   assign status.is_sample  = cmd_ff == gri_pkg::CMD_SAMPLE;
   assign status.idx        = idx_ff;
   assign status.mode       = mode_ff;
   assign status.scale_zero = sel_scale == '0;
   assign status.div_last   = dcnt_ff == gri_pkg::DIV_LAST;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == gri_pkg::OP_SACC || cmd.op == gri_pkg::OP_AFIN)
      |=> idx_ff != gri_pkg::AXIS_NONE)
      else $error("axis index left range after axis step");
   a_settle_rise: assert property (@(posedge clock) disable iff (reset)
      (settle_ff > $past(settle_ff))
      |-> $past(cmd.op == gri_pkg::OP_UPDATE && cmd_ff == gri_pkg::CMD_RESET_ALL))
      else $error("settle count rose without reset-all");
   a_cal_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(cal_ff)
      |-> $past(cmd.op == gri_pkg::OP_UPDATE && cmd_ff == gri_pkg::CMD_CALIBRATE))
      else $error("calibration phase changed outside calibrate step");
`endif

endmodule

// ----- hdl/gri_ctrl.sv -----
// Sequencer of the gyro rate integrator: steps the datapath through update,
// accumulation and the per-axis angle computation. Uses gri_pkg.
module gri_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output gri_pkg::dp_cmd_type    cmd,
   input  gri_pkg::dp_status_type status
);

   gri_pkg::ctl_state_type state_ff;
   gri_pkg::ctl_state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic mode_known;

   assign mode_known = status.mode == gri_pkg::MODE_DEGREES
                    || status.mode == gri_pkg::MODE_RADIANS
                    || status.mode == gri_pkg::MODE_RAW;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gri_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = gri_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         gri_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = gri_pkg::OP_LOAD;
               state_in = gri_pkg::ST_UPDATE;
            end
         end
         gri_pkg::ST_UPDATE: begin
            cmd.op   = gri_pkg::OP_UPDATE;
            state_in = status.is_sample ? gri_pkg::ST_SMUL : gri_pkg::ST_ASTART;
         end
         gri_pkg::ST_SMUL: begin
            cmd.op   = gri_pkg::OP_SMUL;
            state_in = gri_pkg::ST_SACC;
         end
         gri_pkg::ST_SACC: begin
            cmd.op   = gri_pkg::OP_SACC;
            state_in = (status.idx == gri_pkg::AXIS_LAST) ? gri_pkg::ST_ASTART
                                                          : gri_pkg::ST_SMUL;
         end
         gri_pkg::ST_ASTART: begin
            if (!mode_known
                || (status.mode != gri_pkg::MODE_RAW && status.scale_zero)) begin
               state_in = gri_pkg::ST_AFIN;
            end else begin
               state_in = gri_pkg::ST_MLO;
            end
         end
         gri_pkg::ST_MLO: begin
            cmd.op   = gri_pkg::OP_MLO;
            state_in = gri_pkg::ST_MHI;
         end
         gri_pkg::ST_MHI: begin
            cmd.op   = gri_pkg::OP_MHI;
            state_in = (status.mode == gri_pkg::MODE_RAW) ? gri_pkg::ST_AFIN
                                                          : gri_pkg::ST_DINIT;
         end
         gri_pkg::ST_DINIT: begin
            cmd.op   = gri_pkg::OP_DINIT;
            state_in = gri_pkg::ST_DIV;
         end
         gri_pkg::ST_DIV: begin
            cmd.op = gri_pkg::OP_DIV;
            if (status.div_last) begin
               state_in = (status.mode == gri_pkg::MODE_RADIANS) ? gri_pkg::ST_RLO
                                                                 : gri_pkg::ST_AFIN;
            end
         end
         gri_pkg::ST_RLO: begin
            cmd.op   = gri_pkg::OP_RLO;
            state_in = gri_pkg::ST_RHI;
         end
         gri_pkg::ST_RHI: begin
            cmd.op   = gri_pkg::OP_RHI;
            state_in = gri_pkg::ST_AFIN;
         end
         gri_pkg::ST_AFIN: begin
            cmd.op   = gri_pkg::OP_AFIN;
            state_in = (status.idx == gri_pkg::AXIS_LAST) ? gri_pkg::ST_OUT
                                                          : gri_pkg::ST_ASTART;
         end
         gri_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = gri_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = gri_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gri_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = state_ff == gri_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hdl/gyro_rate_integrator_unit.sv -----
// Gyro rate integrator, top level: stream ports, configuration port and the
// controller and datapath instances. Uses gri_pkg, gri_ctrl and gri_datapath.
// Angle computation: degrees mode runs three 80-step divisions on one shared restoring divider;
//   radians mode adds a further multiply per axis, and raw mode needs no division; a sample adds
//   the accumulation steps, and an axis with zero scale or with mode three skips its division.
// Flow: a new item is taken only in idle, once the last one is done; the result register frees the input side.
// Reset: synchronous; restores register and axis state, settle count to START_SETTLE.
module gyro_rate_integrator_unit #(
   parameter int          START_SETTLE  = 200,
   parameter int          RESET_SETTLE  = 100,
   parameter logic [47:0] DEFAULT_SCALE = 48'd4000000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // rate_x, rate_y, rate_z, interval_ticks, scale_in
   input  logic [4:0]   req_tuser,  // cmd, axis
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,  // angle_x, angle_y, angle_z, calibrating, scale_out, zeros
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   gri_pkg::dp_cmd_type    cmd;
   gri_pkg::dp_status_type status;
   logic [31:0] angle_x;
   logic [31:0] angle_y;
   logic [31:0] angle_z;
   logic        calibrating;
   logic [47:0] scale_out;

   assign csr_ready = 1'b1;

   gri_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gri_datapath #(
      .START_SETTLE  (START_SETTLE),
      .RESET_SETTLE  (RESET_SETTLE),
      .DEFAULT_SCALE (DEFAULT_SCALE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cmd            (req_tuser[2:0]),
      .req_axis           (req_tuser[4:3]),
      .req_rate_x         (req_tdata[15:0]),
      .req_rate_y         (req_tdata[31:16]),
      .req_rate_z         (req_tdata[47:32]),
      .req_interval_ticks (req_tdata[79:48]),
      .req_scale_in       (req_tdata[127:80]),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_angle_x        (angle_x),
      .rsp_angle_y        (angle_y),
      .rsp_angle_z        (angle_z),
      .rsp_calibrating    (calibrating),
      .rsp_scale_out      (scale_out)
   );

   assign rsp_tdata = {7'd0, scale_out, calibrating, angle_z, angle_y, angle_x};

endmodule
